// ===== hw/rtl/finite_difference_threshold_detector_defines.svh =====
// Assertion macros shared by the detector RTL.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef FINITE_DIFFERENCE_THRESHOLD_DETECTOR_DEFINES_SVH
`define FINITE_DIFFERENCE_THRESHOLD_DETECTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FDTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fdtd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FDTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fdtd assertion failed");

`endif

// ===== hw/rtl/fdtd_pkg.sv =====
// Package for the finite-difference threshold detector.
// Holds widths, register codes, queue entry types and tap address arithmetic.
`timescale 1ns / 1ps
`default_nettype none

package fdtd_pkg;

    localparam int MAX_DELTA  = 64;
    localparam int SAMPLE_W   = 24;
    localparam int INDEX_W    = 16;
    localparam int DELTA_W    = 7;
    localparam int GAIN_W     = 32;
    localparam int VALUE_W    = 32;
    localparam int FRAC_W     = 24;
    localparam int LINE_DEPTH = 3 * MAX_DELTA + 1;
    localparam int POS_W      = $clog2(LINE_DEPTH);
    localparam int DIFF_W     = SAMPLE_W + 2;
    localparam int PROD_W     = DIFF_W + GAIN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THR_EN    = 3'd4;

    localparam logic MODE_ACCEL = 1'b0;
    localparam logic MODE_SLOPE = 1'b1;

    localparam logic [DELTA_W-1:0] DELTA_RESET = 7'd1;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 32'h0100_0000;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic [INDEX_W-1:0]       center;
        logic signed [DIFF_W-1:0] diff;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    typedef struct packed {
        logic avail;
        t_job job;
    } t_head;

    function automatic logic [POS_W-1:0] tap_addr(input logic [POS_W-1:0] pos,
                                                   input logic [POS_W-1:0] back);
        logic [POS_W:0] sum;
        sum = {1'b0, pos} + (POS_W + 1)'(LINE_DEPTH) - {1'b0, back};
        if (sum >= (POS_W + 1)'(LINE_DEPTH)) begin
            sum = sum - (POS_W + 1)'(LINE_DEPTH);
        end
        return sum[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fdtd_front.sv =====
// Front end: accepts samples, keeps the delay line and classifies each item.
// Reads the three taps from copies of the line and pushes a difference job.
// Depends on fdtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdtd_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [fdtd_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                                  i_last,
    input  wire logic                                  i_mode,
    input  wire logic [fdtd_pkg::DELTA_W-1:0]          i_delta,
    input  wire logic                                  i_full,
    output fdtd_pkg::t_push                            o_push
);

    logic signed [fdtd_pkg::SAMPLE_W-1:0] r_line_a [fdtd_pkg::LINE_DEPTH];
    logic signed [fdtd_pkg::SAMPLE_W-1:0] r_line_b [fdtd_pkg::LINE_DEPTH];
    logic signed [fdtd_pkg::SAMPLE_W-1:0] r_line_c [fdtd_pkg::LINE_DEPTH];

    logic [fdtd_pkg::POS_W-1:0]           r_wr_pos;
    logic [fdtd_pkg::POS_W-1:0]           n_wr_pos;
    logic [fdtd_pkg::INDEX_W-1:0]         r_count;
    logic [fdtd_pkg::INDEX_W-1:0]         n_count;
    logic                                 r_f1_valid;

    logic signed [fdtd_pkg::SAMPLE_W-1:0] r_x;
    logic signed [fdtd_pkg::SAMPLE_W-1:0] r_tap1;
    logic signed [fdtd_pkg::SAMPLE_W-1:0] r_tap2;
    logic signed [fdtd_pkg::SAMPLE_W-1:0] r_tap3;
    logic                                 r_k_valid;
    logic                                 r_last;
    logic [fdtd_pkg::INDEX_W-1:0]         r_center;

    logic                                 w_accept;
    logic                                 w_push;
    logic [fdtd_pkg::DELTA_W-1:0]         w_d;
    logic [fdtd_pkg::POS_W-1:0]           w_back1;
    logic [fdtd_pkg::POS_W-1:0]           w_back2;
    logic [fdtd_pkg::POS_W-1:0]           w_back3;
    logic [fdtd_pkg::POS_W-1:0]           w_addr1;
    logic [fdtd_pkg::POS_W-1:0]           w_addr2;
    logic [fdtd_pkg::POS_W-1:0]           w_addr3;
    logic                                 w_k_valid;
    logic [fdtd_pkg::INDEX_W-1:0]         w_center;
    logic signed [fdtd_pkg::DIFF_W-1:0]   w_x;
    logic signed [fdtd_pkg::DIFF_W-1:0]   w_t1;
    logic signed [fdtd_pkg::DIFF_W-1:0]   w_t2;
    logic signed [fdtd_pkg::DIFF_W-1:0]   w_t3;
    logic signed [fdtd_pkg::DIFF_W-1:0]   w_diff;

    assign w_push   = r_f1_valid && !i_full;
    assign o_stall  = r_f1_valid && i_full;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        if (i_delta == '0) begin
            w_d = fdtd_pkg::DELTA_W'(1);
        end else if (i_delta > fdtd_pkg::DELTA_W'(fdtd_pkg::MAX_DELTA)) begin
            w_d = fdtd_pkg::DELTA_W'(fdtd_pkg::MAX_DELTA);
        end else begin
            w_d = i_delta;
        end
        w_back1 = fdtd_pkg::POS_W'(w_d);
        w_back2 = fdtd_pkg::POS_W'({w_d, 1'b0});
        w_back3 = w_back1 + w_back2;
        w_addr1 = fdtd_pkg::tap_addr(r_wr_pos, w_back1);
        w_addr2 = fdtd_pkg::tap_addr(r_wr_pos, w_back2);
        w_addr3 = fdtd_pkg::tap_addr(r_wr_pos, w_back3);
        w_k_valid = r_count >= fdtd_pkg::INDEX_W'(w_back3);
        w_center  = w_k_valid ? (r_count - fdtd_pkg::INDEX_W'(w_back2)) : '0;
    end

    always_comb begin
        if (r_wr_pos == fdtd_pkg::POS_W'(fdtd_pkg::LINE_DEPTH - 1)) begin
            n_wr_pos = '0;
        end else begin
            n_wr_pos = r_wr_pos + fdtd_pkg::POS_W'(1);
        end
        if (i_last) begin
            n_count = '0;
        end else if (r_count != '1) begin
            n_count = r_count + fdtd_pkg::INDEX_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_line_a[r_wr_pos] <= i_sample;
            r_tap1             <= r_line_a[w_addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_line_b[r_wr_pos] <= i_sample;
            r_tap2             <= r_line_b[w_addr2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_line_c[r_wr_pos] <= i_sample;
            r_tap3             <= r_line_c[w_addr3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x       <= i_sample;
            r_k_valid <= w_k_valid;
            r_last    <= i_last;
            r_center  <= w_center;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos   <= '0;
            r_count    <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_wr_pos   <= n_wr_pos;
                r_count    <= n_count;
                r_f1_valid <= 1'b1;
            end else if (w_push) begin
                r_f1_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        w_x  = fdtd_pkg::DIFF_W'(r_x);
        w_t1 = fdtd_pkg::DIFF_W'(r_tap1);
        w_t2 = fdtd_pkg::DIFF_W'(r_tap2);
        w_t3 = fdtd_pkg::DIFF_W'(r_tap3);
        if (!r_k_valid) begin
            w_diff = '0;
        end else if (i_mode == fdtd_pkg::MODE_SLOPE) begin
            w_diff = w_t1 - w_t3;
        end else begin
            w_diff = w_x - w_t2 - w_t1 + w_t3;
        end
        o_push.push       = w_push;
        o_push.job.valid  = r_k_valid;
        o_push.job.last   = r_last;
        o_push.job.center = r_center;
        o_push.job.diff   = w_diff;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fdtd_fifo.sv =====
// Short job queue between the front end and the back end.
// Register array with count; depends on fdtd_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "finite_difference_threshold_detector_defines.svh"

module fdtd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire fdtd_pkg::t_push i_push,
    output logic                 o_full,
    output fdtd_pkg::t_head      o_head,
    input  wire logic            i_pop
);

    fdtd_pkg::t_job                  r_slot [fdtd_pkg::FIFO_DEPTH];
    logic [fdtd_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [fdtd_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [fdtd_pkg::FIFO_CNT_W-1:0] r_count;
    logic                            w_push;
    logic                            w_pop;

    assign w_push       = i_push.push;
    assign w_pop        = i_pop;
    assign o_full       = r_count == fdtd_pkg::FIFO_CNT_W'(fdtd_pkg::FIFO_DEPTH);
    assign o_head.avail = r_count != '0;
    assign o_head.job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + fdtd_pkg::FIFO_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + fdtd_pkg::FIFO_PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + fdtd_pkg::FIFO_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - fdtd_pkg::FIFO_CNT_W'(1);
            end
        end
    end

    `FDTD_ASSERT_NOW(a_no_overflow, w_push, !o_full)
    `FDTD_ASSERT_NOW(a_no_underflow, w_pop, r_count != '0)
    `FDTD_ASSERT_NEXT(a_count_grows, w_push && !w_pop, r_count == $past(r_count) + 3'd1)
    `FDTD_ASSERT_NEXT(a_count_shrinks, w_pop && !w_push, r_count == $past(r_count) - 3'd1)

endmodule

`default_nettype wire

// ===== hw/rtl/fdtd_back.sv =====
// Back end: scales each difference by the gain, saturates, tracks the peak
// and the first threshold crossing, and holds the result register.
// Depends on fdtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdtd_back (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire fdtd_pkg::t_head                      i_head,
    output logic                                      o_pop,
    input  wire logic signed [fdtd_pkg::GAIN_W-1:0]   i_gain,
    input  wire logic signed [fdtd_pkg::VALUE_W-1:0]  i_threshold,
    input  wire logic                                 i_thr_en,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [fdtd_pkg::VALUE_W-1:0]       o_value,
    output logic                                      o_value_valid,
    output logic [fdtd_pkg::INDEX_W-1:0]              o_center_index,
    output logic                                      o_crossing_found,
    output logic [fdtd_pkg::INDEX_W-1:0]              o_crossing_index,
    output logic signed [fdtd_pkg::VALUE_W-1:0]       o_max_value,
    output logic                                      o_run_end
);

    localparam int HEAD_W = fdtd_pkg::PROD_W - fdtd_pkg::VALUE_W + 1;
    localparam logic signed [fdtd_pkg::PROD_W-1:0] ROUND_BIAS =
        fdtd_pkg::PROD_W'((64'd1 << fdtd_pkg::FRAC_W) - 64'd1);
    localparam logic signed [fdtd_pkg::VALUE_W-1:0] VALUE_MAX =
        {1'b0, {(fdtd_pkg::VALUE_W - 1){1'b1}}};
    localparam logic signed [fdtd_pkg::VALUE_W-1:0] VALUE_MIN =
        {1'b1, {(fdtd_pkg::VALUE_W - 1){1'b0}}};

    logic                                   r_s1_valid;
    logic signed [fdtd_pkg::PROD_W-1:0]     r_s1_prod;
    logic                                   r_s1_k_valid;
    logic                                   r_s1_last;
    logic [fdtd_pkg::INDEX_W-1:0]           r_s1_center;

    logic                                   r_s2_valid;
    logic signed [fdtd_pkg::VALUE_W-1:0]    r_s2_value;
    logic                                   r_s2_k_valid;
    logic                                   r_s2_last;
    logic [fdtd_pkg::INDEX_W-1:0]           r_s2_center;

    logic                                   r_out_valid;
    logic signed [fdtd_pkg::VALUE_W-1:0]    r_out_value;
    logic                                   r_out_k_valid;
    logic [fdtd_pkg::INDEX_W-1:0]           r_out_center;
    logic                                   r_out_found;
    logic [fdtd_pkg::INDEX_W-1:0]           r_out_cross_idx;
    logic signed [fdtd_pkg::VALUE_W-1:0]    r_out_max;
    logic                                   r_out_last;

    logic signed [fdtd_pkg::VALUE_W-1:0]    r_peak;
    logic signed [fdtd_pkg::VALUE_W-1:0]    n_peak;
    logic                                   r_crossed;
    logic                                   n_crossed;
    logic [fdtd_pkg::INDEX_W-1:0]           r_cross_idx;
    logic [fdtd_pkg::INDEX_W-1:0]           n_cross_idx;

    logic                                   w_rdy3;
    logic                                   w_rdy2;
    logic                                   w_rdy1;
    logic                                   w_load3;
    logic                                   w_load2;
    logic signed [fdtd_pkg::DIFF_W-1:0]     w_diff;
    logic signed [fdtd_pkg::PROD_W-1:0]     w_prod;
    logic signed [fdtd_pkg::PROD_W-1:0]     w_rounded;
    logic signed [fdtd_pkg::PROD_W-1:0]     w_shifted;
    logic [HEAD_W-1:0]                      w_head_bits;
    logic signed [fdtd_pkg::VALUE_W-1:0]    w_sat;

    assign w_rdy3  = !r_out_valid || !i_stall;
    assign w_rdy2  = !r_s2_valid || w_rdy3;
    assign w_rdy1  = !r_s1_valid || w_rdy2;
    assign o_pop   = i_head.avail && w_rdy1;
    assign w_load2 = r_s1_valid && w_rdy2;
    assign w_load3 = r_s2_valid && w_rdy3;

    assign w_diff = i_head.job.diff;
    assign w_prod = w_diff * i_gain;

    always_comb begin
        w_rounded   = r_s1_prod + (r_s1_prod[fdtd_pkg::PROD_W-1] ? ROUND_BIAS : '0);
        w_shifted   = w_rounded >>> fdtd_pkg::FRAC_W;
        w_head_bits = w_shifted[fdtd_pkg::PROD_W-1:fdtd_pkg::VALUE_W-1];
        if (w_head_bits == '0 || w_head_bits == '1) begin
            w_sat = w_shifted[fdtd_pkg::VALUE_W-1:0];
        end else if (w_shifted[fdtd_pkg::PROD_W-1]) begin
            w_sat = VALUE_MIN;
        end else begin
            w_sat = VALUE_MAX;
        end
    end

    always_comb begin
        n_peak      = r_peak;
        n_crossed   = r_crossed;
        n_cross_idx = r_cross_idx;
        if (r_s2_k_valid) begin
            if (r_s2_value > r_peak) begin
                n_peak = r_s2_value;
            end
            if (i_thr_en && !r_crossed && (r_s2_value > i_threshold)) begin
                n_crossed   = 1'b1;
                n_cross_idx = r_s2_center;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_prod    <= w_prod;
            r_s1_k_valid <= i_head.job.valid;
            r_s1_last    <= i_head.job.last;
            r_s1_center  <= i_head.job.center;
        end
        if (w_load2) begin
            r_s2_value   <= w_sat;
            r_s2_k_valid <= r_s1_k_valid;
            r_s2_last    <= r_s1_last;
            r_s2_center  <= r_s1_center;
        end
        if (w_load3) begin
            r_out_value     <= r_s2_value;
            r_out_k_valid   <= r_s2_k_valid;
            r_out_center    <= r_s2_center;
            r_out_found     <= n_crossed;
            r_out_cross_idx <= n_crossed ? n_cross_idx : '0;
            r_out_max       <= n_peak;
            r_out_last      <= r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_peak      <= '0;
            r_crossed   <= 1'b0;
            r_cross_idx <= '0;
        end else begin
            if (w_rdy1) begin
                r_s1_valid <= o_pop;
            end
            if (w_rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_rdy3) begin
                r_out_valid <= r_s2_valid;
            end
            if (w_load3) begin
                if (r_s2_last) begin
                    r_peak      <= '0;
                    r_crossed   <= 1'b0;
                    r_cross_idx <= '0;
                end else begin
                    r_peak      <= n_peak;
                    r_crossed   <= n_crossed;
                    r_cross_idx <= n_cross_idx;
                end
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_value          = r_out_value;
    assign o_value_valid    = r_out_k_valid;
    assign o_center_index   = r_out_center;
    assign o_crossing_found = r_out_found;
    assign o_crossing_index = r_out_cross_idx;
    assign o_max_value      = r_out_max;
    assign o_run_end        = r_out_last;

endmodule

`default_nettype wire

// ===== hw/rtl/finite_difference_threshold_detector.sv =====
// Top level of the finite-difference threshold detector: configuration
// registers, front end, job queue and back end. Depends on fdtd_pkg.
//
//   channel   dir  handshake               payload
//   sample    in   i_valid / o_stall       i_sample, i_last
//   result    out  o_valid / i_stall       o_value .. o_run_end
//   config    in   i_cfg_wr_en             i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while the queue has room; a result is registered
// in turn at tap read, queue, multiply, scale and saturate, and peak and crossing update.
// The multiply and the three tap reads, one per copy of the line, are each registered.
// Synchronous active-low reset clears control, run state and configuration;
// the delay line is not cleared and needs no clearing pass.
// A stalled result fills the back end and then the 4-entry queue before
// the sample side stalls.
`timescale 1ns / 1ps
`default_nettype none

module finite_difference_threshold_detector (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [fdtd_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                                  i_last,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [fdtd_pkg::VALUE_W-1:0]        o_value,
    output logic                                       o_value_valid,
    output logic [fdtd_pkg::INDEX_W-1:0]               o_center_index,
    output logic                                       o_crossing_found,
    output logic [fdtd_pkg::INDEX_W-1:0]               o_crossing_index,
    output logic signed [fdtd_pkg::VALUE_W-1:0]        o_max_value,
    output logic                                       o_run_end,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [fdtd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [fdtd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic                                 r_mode;
    logic [fdtd_pkg::DELTA_W-1:0]         r_delta;
    logic signed [fdtd_pkg::GAIN_W-1:0]   r_gain;
    logic signed [fdtd_pkg::VALUE_W-1:0]  r_threshold;
    logic                                 r_thr_en;

    fdtd_pkg::t_push                      w_push;
    fdtd_pkg::t_head                      w_head;
    logic                                 w_full;
    logic                                 w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= fdtd_pkg::MODE_ACCEL;
            r_delta     <= fdtd_pkg::DELTA_RESET;
            r_gain      <= fdtd_pkg::GAIN_RESET;
            r_threshold <= '0;
            r_thr_en    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                fdtd_pkg::REG_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                fdtd_pkg::REG_DELTA: begin
                    r_delta <= i_cfg_data[fdtd_pkg::DELTA_W-1:0];
                end
                fdtd_pkg::REG_GAIN: begin
                    r_gain <= i_cfg_data[fdtd_pkg::GAIN_W-1:0];
                end
                fdtd_pkg::REG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[fdtd_pkg::VALUE_W-1:0];
                end
                fdtd_pkg::REG_THR_EN: begin
                    r_thr_en <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    fdtd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (i_sample),
        .i_last   (i_last),
        .i_mode   (r_mode),
        .i_delta  (r_delta),
        .i_full   (w_full),
        .o_push   (w_push)
    );

    fdtd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    fdtd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .o_pop            (w_pop),
        .i_gain           (r_gain),
        .i_threshold      (r_threshold),
        .i_thr_en         (r_thr_en),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_value          (o_value),
        .o_value_valid    (o_value_valid),
        .o_center_index   (o_center_index),
        .o_crossing_found (o_crossing_found),
        .o_crossing_index (o_crossing_index),
        .o_max_value      (o_max_value),
        .o_run_end        (o_run_end)
    );

endmodule

`default_nettype wire

// ===== tb/sv/fdtd_checker.sv =====
// Result checker for the finite-difference threshold detector: watches the sample,
// result and register-write ports, predicts each result and compares it field by field.
// Depends on fdtd_pkg for widths, register codes and reset values.
`timescale 1ns / 1ps

module fdtd_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic signed [fdtd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_last,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [fdtd_pkg::VALUE_W-1:0]  i_value,
    input  logic                                 i_value_valid,
    input  logic [fdtd_pkg::INDEX_W-1:0]         i_center_index,
    input  logic                                 i_crossing_found,
    input  logic [fdtd_pkg::INDEX_W-1:0]         i_crossing_index,
    input  logic signed [fdtd_pkg::VALUE_W-1:0]  i_max_value,
    input  logic                                 i_run_end,
    input  logic                                 i_cfg_wr_en,
    input  logic [fdtd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fdtd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    localparam int DEPTH = fdtd_pkg::LINE_DEPTH;

    typedef struct packed {
        logic signed [fdtd_pkg::VALUE_W-1:0] value;
        logic                                value_valid;
        logic [fdtd_pkg::INDEX_W-1:0]        center_index;
        logic                                crossing_found;
        logic [fdtd_pkg::INDEX_W-1:0]        crossing_index;
        logic signed [fdtd_pkg::VALUE_W-1:0] max_value;
        logic                                run_end;
    } t_detect_result;

    // detector state
    logic signed [fdtd_pkg::SAMPLE_W-1:0] line_mem [0:DEPTH-1];
    int                                   wr_pos;
    logic [fdtd_pkg::INDEX_W-1:0]         run_count;
    logic                                 crossed;
    logic [fdtd_pkg::INDEX_W-1:0]         cross_idx;
    logic signed [fdtd_pkg::VALUE_W-1:0]  peak;

    // register copy
    logic                                 mode_r;
    logic [fdtd_pkg::DELTA_W-1:0]         delta_r;
    logic signed [fdtd_pkg::GAIN_W-1:0]   gain_r;
    logic signed [fdtd_pkg::VALUE_W-1:0]  thr_r;
    logic                                 thr_en_r;

    t_detect_result expected_results [$];
    t_detect_result want;
    t_detect_result got;

    function automatic longint tap_sample(input int back);
        return longint'(line_mem[(wr_pos + DEPTH - back) % DEPTH]);
    endfunction

    task automatic reset_detector();
        for (int i = 0; i < DEPTH; i++) begin
            line_mem[i] = '0;
        end
        wr_pos    = 0;
        run_count = '0;
        crossed   = 1'b0;
        cross_idx = '0;
        peak      = '0;
        mode_r    = fdtd_pkg::MODE_ACCEL;
        delta_r   = fdtd_pkg::DELTA_RESET;
        gain_r    = fdtd_pkg::GAIN_RESET;
        thr_r     = '0;
        thr_en_r  = 1'b0;
    endtask

    task automatic apply_reg_write(input logic [fdtd_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [fdtd_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            fdtd_pkg::REG_MODE:      mode_r   = data[0];
            fdtd_pkg::REG_DELTA:     delta_r  = data[fdtd_pkg::DELTA_W-1:0];
            fdtd_pkg::REG_GAIN:      gain_r   = data;
            fdtd_pkg::REG_THRESHOLD: thr_r    = data;
            fdtd_pkg::REG_THR_EN:    thr_en_r = data[0];
            default: ;
        endcase
    endtask

    task automatic step_detector(input logic signed [fdtd_pkg::SAMPLE_W-1:0] sample,
                                 input logic last, output t_detect_result res);
        int                                  d;
        longint                              diff;
        longint                              prod;
        longint                              mag;
        logic signed [fdtd_pkg::VALUE_W-1:0] val;
        d = int'(delta_r);
        if (d < 1) begin
            d = 1;
        end
        if (d > fdtd_pkg::MAX_DELTA) begin
            d = fdtd_pkg::MAX_DELTA;
        end
        line_mem[wr_pos] = sample;
        res = '0;
        res.run_end = last;
        if (int'(run_count) >= 3 * d) begin
            if (mode_r == fdtd_pkg::MODE_ACCEL) begin
                diff = longint'(sample) - tap_sample(2 * d) - tap_sample(d)
                       + tap_sample(3 * d);
            end else begin
                diff = tap_sample(d) - tap_sample(3 * d);
            end
            prod = diff * longint'(gain_r);
            // truncate toward zero, then saturate
            if (prod < 0) begin
                mag = (-prod) >>> fdtd_pkg::FRAC_W;
                val = (mag >= 64'sd2147483648) ? 32'sh8000_0000 : 32'(-mag);
            end else begin
                mag = prod >>> fdtd_pkg::FRAC_W;
                val = (mag > 64'sd2147483647) ? 32'sh7FFF_FFFF : 32'(mag);
            end
            res.value        = val;
            res.value_valid  = 1'b1;
            res.center_index = fdtd_pkg::INDEX_W'(int'(run_count) - 2 * d);
            if (val > peak) begin
                peak = val;
            end
            if (thr_en_r && !crossed && val > thr_r) begin
                crossed   = 1'b1;
                cross_idx = res.center_index;
            end
        end
        res.crossing_found = crossed;
        res.crossing_index = crossed ? cross_idx : '0;
        res.max_value      = peak;
        wr_pos = (wr_pos + 1) % DEPTH;
        if (run_count != '1) begin
            run_count = run_count + 1'b1;
        end
        if (last) begin
            run_count = '0;
            crossed   = 1'b0;
            cross_idx = '0;
            peak      = '0;
        end
    endtask

    task automatic report_field(input string field, input longint want_v, input longint got_v);
        o_fail_count++;
        $error("%s: expected %0d, actual %0d", field, want_v, got_v);
    endtask

    task automatic compare_result(input t_detect_result w, input t_detect_result g);
        if (g.value !== w.value) begin
            report_field("value", longint'(w.value), longint'(g.value));
        end
        if (g.value_valid !== w.value_valid) begin
            report_field("value_valid", w.value_valid, g.value_valid);
        end
        if (g.center_index !== w.center_index) begin
            report_field("center_index", w.center_index, g.center_index);
        end
        if (g.crossing_found !== w.crossing_found) begin
            report_field("crossing_found", w.crossing_found, g.crossing_found);
        end
        if (g.crossing_index !== w.crossing_index) begin
            report_field("crossing_index", w.crossing_index, g.crossing_index);
        end
        if (g.max_value !== w.max_value) begin
            report_field("max_value", longint'(w.max_value), longint'(g.max_value));
        end
        if (g.run_end !== w.run_end) begin
            report_field("run_end", w.run_end, g.run_end);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_detector();
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.value          = i_value;
                got.value_valid    = i_value_valid;
                got.center_index   = i_center_index;
                got.crossing_found = i_crossing_found;
                got.crossing_index = i_crossing_index;
                got.max_value      = i_max_value;
                got.run_end        = i_run_end;
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $error("result transfer with no sample outstanding");
                end else begin
                    want = expected_results.pop_front();
                    compare_result(want, got);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                step_detector(i_sample, i_last, want);
                expected_results.push_back(want);
            end
            if (i_cfg_wr_en) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/sv/tb_finite_difference_threshold_detector.sv =====
// Testbench top for the finite-difference threshold detector: clock, reset, sample
// stimulus, result-side stalls and register writes; checking is done by fdtd_checker.
// Depends on fdtd_pkg, fdtd_checker and the detector RTL.
`timescale 1ns / 1ps

module tb_finite_difference_threshold_detector;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES  = 64;
    localparam int LONG_RUN     = 100;

    localparam logic [fdtd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = fdtd_pkg::REG_THR_EN + 1'b1;

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_valid     = 1'b0;
    logic signed [fdtd_pkg::SAMPLE_W-1:0] i_sample    = '0;
    logic                                 i_last      = 1'b0;
    logic                                 i_stall     = 1'b0;
    logic                                 i_cfg_wr_en = 1'b0;
    logic [fdtd_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [fdtd_pkg::CFG_DATA_W-1:0]      i_cfg_data  = '0;

    logic                                 o_stall;
    logic                                 o_valid;
    logic signed [fdtd_pkg::VALUE_W-1:0]  o_value;
    logic                                 o_value_valid;
    logic [fdtd_pkg::INDEX_W-1:0]         o_center_index;
    logic                                 o_crossing_found;
    logic [fdtd_pkg::INDEX_W-1:0]         o_crossing_index;
    logic signed [fdtd_pkg::VALUE_W-1:0]  o_max_value;
    logic                                 o_run_end;

    int fail_count;
    int pending;

    int send_idle_pct = 21;
    int stall_pct     = 78;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int random_sent   = 0;
    int cycle_count   = 0;
    logic [fdtd_pkg::DELTA_W-1:0] cur_delta = fdtd_pkg::DELTA_RESET;

    finite_difference_threshold_detector DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample         (i_sample),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_value          (o_value),
        .o_value_valid    (o_value_valid),
        .o_center_index   (o_center_index),
        .o_crossing_found (o_crossing_found),
        .o_crossing_index (o_crossing_index),
        .o_max_value      (o_max_value),
        .o_run_end        (o_run_end),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    fdtd_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_sample         (i_sample),
        .i_last           (i_last),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_value          (o_value),
        .i_value_valid    (o_value_valid),
        .i_center_index   (o_center_index),
        .i_crossing_found (o_crossing_found),
        .i_crossing_index (o_crossing_index),
        .i_max_value      (o_max_value),
        .i_run_end        (o_run_end),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic logic signed [fdtd_pkg::SAMPLE_W-1:0] gen_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 24'sh7F_FFFF;
                    1: return 24'sh80_0000;
                    2: return 24'sh00_0000;
                    default: return 24'shFF_FFFF;
                endcase
            end
            1, 2, 3: return fdtd_pkg::SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
            default: return fdtd_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic write_reg(input logic [fdtd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fdtd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == fdtd_pkg::REG_DELTA) begin
            cur_delta = data[fdtd_pkg::DELTA_W-1:0];
        end
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic signed [fdtd_pkg::SAMPLE_W-1:0] s, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        i_last   <= l;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // hold the sample side until every result is out, then let the pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input bit forced);
        int                              eff_d;
        int                              n_runs;
        int                              len;
        int                              kind;
        logic [fdtd_pkg::CFG_DATA_W-1:0] data;
        if (forced || $urandom_range(0, 1)) begin
            write_reg(fdtd_pkg::REG_MODE, $urandom());
        end
        if (forced || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0: data = 32'd0;
                1: data = fdtd_pkg::MAX_DELTA;
                2: data = $urandom_range(fdtd_pkg::MAX_DELTA + 1, 127);
                3: data = $urandom_range(1, fdtd_pkg::MAX_DELTA);
                default: data = $urandom_range(1, 6);
            endcase
            if (forced) begin
                data = 32'd127;
            end
            if ($urandom_range(0, 3) == 0) begin
                data = data | ($urandom() & 32'hFFFF_FF80);
            end
            write_reg(fdtd_pkg::REG_DELTA, data);
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0: data = 32'h7FFF_FFFF;
                1: data = 32'h8000_0000;
                2: data = 32'h0000_0000;
                3, 4: data = $urandom();
                default: data = 32'(int'($urandom_range(0, 134217728)) - 67108864);
            endcase
            write_reg(fdtd_pkg::REG_GAIN, data);
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
                0: data = 32'h7FFF_FFFF;
                1: data = 32'h8000_0000;
                2: data = $urandom();
                3, 4: data = 32'(int'($urandom_range(0, 2000)) - 1000);
                default: data = 32'(int'($urandom_range(0, 67108864)) - 33554432);
            endcase
            write_reg(fdtd_pkg::REG_THRESHOLD, data);
        end
        if ($urandom_range(0, 1)) begin
            write_reg(fdtd_pkg::REG_THR_EN, $urandom());
        end
        if ($urandom_range(0, 7) == 0) begin
            write_reg(REG_SPARE_LO + fdtd_pkg::CFG_IDX_W'($urandom_range(0, 2)), $urandom());
        end
        i_cfg_wr_en <= 1'b0;

        eff_d = int'(cur_delta);
        if (eff_d < 1) begin
            eff_d = 1;
        end
        if (eff_d > fdtd_pkg::MAX_DELTA) begin
            eff_d = fdtd_pkg::MAX_DELTA;
        end
        n_runs = (eff_d > 8) ? 1 : $urandom_range(1, 4);
        if (forced || $urandom_range(0, 5) == 0) begin
            hold_req = 1'b1;
        end
        for (int r = 0; r < n_runs; r++) begin
            kind = forced ? 0 : $urandom_range(0, 9);
            if (kind < 8) begin
                len = 3 * eff_d + $urandom_range(0, 24);
                for (int i = 0; i < len; i++) begin
                    send_item(gen_sample(), i == len - 1);
                end
            end else if (kind == 8) begin
                // too short to give a valid value if it starts a new run
                len = $urandom_range(1, 3 * eff_d);
                for (int i = 0; i < len; i++) begin
                    send_item(gen_sample(), i == len - 1);
                end
            end else begin
                len = $urandom_range(1, 3 * eff_d + 24);
                for (int i = 0; i < len; i++) begin
                    send_item(gen_sample(), $urandom_range(0, 3) == 0);
                end
            end
            random_sent += len;
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: extremes of the sample
        send_item(24'sh7F_FFFF, 1'b0);
        send_item(24'sh80_0000, 1'b0);
        send_item(24'sh7F_FFFF, 1'b0);
        send_item(24'sh80_0000, 1'b0);
        send_item(24'sh00_0000, 1'b0);
        send_item(24'sh00_0001, 1'b0);
        send_item(24'shFF_FFFF, 1'b1);
        drain();

        // acceleration, largest gain: large values of both signs and a crossing
        write_reg(fdtd_pkg::REG_MODE, 32'(fdtd_pkg::MODE_ACCEL));
        write_reg(fdtd_pkg::REG_DELTA, 32'd1);
        write_reg(fdtd_pkg::REG_GAIN, 32'h7FFF_FFFF);
        write_reg(fdtd_pkg::REG_THRESHOLD, 32'd0);
        write_reg(fdtd_pkg::REG_THR_EN, 32'd1);
        i_cfg_wr_en <= 1'b0;
        send_item(24'sh00_0000, 1'b0);
        send_item(24'sh00_0000, 1'b0);
        send_item(24'sh00_0000, 1'b0);
        send_item(24'sh7F_FFFF, 1'b0);
        send_item(24'sh80_0000, 1'b0);
        send_item(24'sh7F_FFFF, 1'b0);
        send_item(24'sh80_0000, 1'b0);
        send_item(24'sh00_0000, 1'b1);
        drain();

        // slope, spacing of zero, most negative gain, negative threshold
        write_reg(fdtd_pkg::REG_MODE, 32'h0000_0003);
        write_reg(fdtd_pkg::REG_DELTA, 32'd0);
        write_reg(fdtd_pkg::REG_GAIN, 32'h8000_0000);
        write_reg(fdtd_pkg::REG_THRESHOLD, 32'hFFFF_FFFB);
        write_reg(fdtd_pkg::REG_THR_EN, 32'hFFFF_FFFF);
        i_cfg_wr_en <= 1'b0;
        send_item(24'sh7F_FFFF, 1'b0);
        send_item(24'sh80_0000, 1'b0);
        send_item(24'sh7F_FFFF, 1'b0);
        send_item(24'sh00_0001, 1'b0);
        send_item(24'shFF_FFFF, 1'b0);
        send_item(24'sh80_0000, 1'b0);
        send_item(24'sh00_0000, 1'b0);
        send_item(24'sh7F_FFFF, 1'b1);
        drain();

        random_phase(1'b1);
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
                send_idle_pct = 21;
                stall_pct     = 78;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 78;
                stall_pct     = 21;
            end else begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            random_phase(1'b0);
        end

        // one unbroken run at full rate with a small spacing
        send_idle_pct = 0;
        stall_pct     = 0;
        write_reg(fdtd_pkg::REG_DELTA, 32'd2);
        write_reg(fdtd_pkg::REG_GAIN, fdtd_pkg::GAIN_RESET);
        write_reg(fdtd_pkg::REG_THRESHOLD, 32'h0100_0000);
        write_reg(fdtd_pkg::REG_THR_EN, 32'd1);
        i_cfg_wr_en <= 1'b0;
        for (int i = 0; i < LONG_RUN; i++) begin
            send_item(gen_sample(), i == LONG_RUN - 1);
        end
        drain();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
